### rtl/row_variance_boundary_finder_assert.svh
// Assertion macros for the row variance boundary finder.
`ifndef ROW_VARIANCE_BOUNDARY_FINDER_ASSERT_SVH
`define ROW_VARIANCE_BOUNDARY_FINDER_ASSERT_SVH
`ifndef SYNTH
`define RVB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RVB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RVB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RVB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/rvbf_pkg.sv
package rvbf_pkg;
	localparam int unsigned MaxWidth  = 4096;
	localparam int unsigned MaxHeight = 4096;
	localparam int unsigned RowIdxW   = 13;
	localparam int unsigned CntW      = 13;
	localparam int unsigned SumW      = 20;
	localparam int unsigned SqW       = 28;
	localparam int unsigned VarW      = 14;
	localparam int unsigned PeakW     = 18;
	localparam int unsigned DivW      = 29;

	localparam logic [12:0] RESET_ROW_WIDTH = 13'd640;
	localparam logic [15:0] RESET_THRESHOLD = 16'd30;
	localparam logic signed [PeakW-1:0] NO_PEAK = -18'sd1000;
	localparam logic signed [RowIdxW-1:0] NO_ROW = -13'sd1;

	localparam logic REG_ROW_WIDTH = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic accum;      // add pixel into row sums
		logic close_row;  // latch sums of the closing row
		logic div_start;
		logic div_sel_var; // 0 mean, 1 variance
		logic mean_load;
		logic dev_load;
		logic var_load;   // shift variance, update peaks
		logic emit;
		logic clear;
	} rvbf_cmd_t;

	typedef struct packed {
		logic row_end;
		logic div_done;
		logic row_counts; // closing row is inside analyzed height
	} rvbf_sts_t;
endpackage

### rtl/rvbf_divider.sv
module rvbf_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rvbf_pkg::DivW-1:0]  dividend,
	input  logic [rvbf_pkg::CntW-1:0]  divisor,
	output logic                       done,
	output logic [rvbf_pkg::DivW-1:0]  quotient
);
	import rvbf_pkg::*;

	logic [DivW-1:0]   quo_q;
	logic [CntW:0]     rem_q;
	logic [CntW-1:0]   den_q;
	logic [4:0]        bit_q;
	logic              busy_q;
	logic [CntW:0]     trial;
	logic [CntW+1:0]   diff;

	assign trial = {rem_q[CntW-1:0], quo_q[DivW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 5'(DivW - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				bit_q <= bit_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CntW+1]) begin
				rem_q <= diff[CntW:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

### rtl/rvbf_datapath.sv
`include "row_variance_boundary_finder_assert.svh"
module rvbf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rvbf_pkg::rvbf_cmd_t           cmd,
	output rvbf_pkg::rvbf_sts_t           sts,
	input  logic [7:0]                    first_channel,
	input  logic [7:0]                    second_channel,
	input  logic [7:0]                    third_channel,
	input  logic                          last_in_frame,
	input  logic [12:0]                   row_width_q,
	input  logic [15:0]                   threshold_q,
	output logic signed [12:0]            first_boundary,
	output logic signed [12:0]            second_boundary,
	output logic [1:0]                    peaks_found
);
	import rvbf_pkg::*;

	logic [CntW-1:0]  cnt_q, n_q, eff_w, cnt_nx;
	logic [SumW-1:0]  sum_q, s_q;
	logic [SqW-1:0]   sq_q, q_q;
	logic [RowIdxW-1:0] row_q;
	logic [9:0]       csum;
	logic [19:0]      y_mul;
	logic [7:0]       y;
	logic [15:0]      ysq;
	logic [DivW-1:0]  div_a, quo;
	logic             div_done;
	logic [7:0]       mean_q;
	logic [DivW-1:0]  dev_q;
	logic [VarW-1:0]  v_q [3];
	logic [1:0]       nvalid_q;
	logic signed [PeakW-1:0] best_v_q, sec_v_q, peak;
	logic signed [RowIdxW-1:0] best_r_q, sec_r_q, at;
	logic signed [VarW+3:0] p;
	logic [VarW-1:0]  var_new;
	logic [20:0]      nmm;
	logic [28:0]      ms2;

	assign csum = 10'(first_channel) + 10'(second_channel) + 10'(third_channel);
	// divide by 3 as a multiply by 683/2048, exact for sums up to 765
	assign y_mul = 20'(csum) * 20'd683;
	assign y    = y_mul[18:11];
	assign ysq  = 16'(y) * 16'(y);
	assign eff_w = (row_width_q == '0) ? 13'd1 :
		(row_width_q > 13'(MaxWidth)) ? 13'(MaxWidth) : row_width_q;
	assign cnt_nx = cnt_q + 13'd1;
	assign sts.row_end = (cnt_nx >= eff_w) || last_in_frame;
	assign sts.row_counts = (row_q < 13'(MaxHeight));
	assign sts.div_done = div_done;

	// row sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.accum) begin
			if (sts.row_end) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_q + 20'(y);
				sq_q  <= sq_q + 28'(ysq);
			end
		end
	end

	// closed row snapshot
	always_ff @(posedge clk) begin
		if (cmd.close_row) begin
			n_q <= cnt_nx;
			s_q <= sum_q + 20'(y);
			q_q <= sq_q + 28'(ysq);
		end
	end

	assign div_a = cmd.div_sel_var ? dev_q : 29'(s_q);
	rvbf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(n_q), .done(div_done), .quotient(quo)
	);

	// deviation sum: q + n*m*m - 2*m*s, each product registered
	always_ff @(posedge clk) begin
		if (cmd.mean_load) begin
			mean_q <= quo[7:0];
			nmm    <= 21'(n_q) * 21'(quo[7:0]);
			ms2    <= 29'(s_q) * 29'({quo[7:0], 1'b0});
		end
		if (cmd.dev_load)
			dev_q <= 29'(30'(q_q) + 30'(nmm) * 30'(mean_q) - 30'(ms2));
	end

	assign var_new = quo[VarW-1:0];
	assign p = 18'(v_q[0]) - 18'sd3 * 18'(v_q[1]) + 18'sd3 * 18'(v_q[2]) - 18'(var_new);
	assign peak = p[PeakW-1] ? -p : p;
	assign at = $signed(row_q) - 13'sd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			nvalid_q <= '0;
			best_v_q <= NO_PEAK;
			sec_v_q  <= NO_PEAK;
			best_r_q <= NO_ROW;
			sec_r_q  <= NO_ROW;
			for (int i = 0; i < 3; i++) v_q[i] <= '0;
		end else if (cmd.clear) begin
			row_q    <= '0;
			nvalid_q <= '0;
			best_v_q <= NO_PEAK;
			sec_v_q  <= NO_PEAK;
			best_r_q <= NO_ROW;
			sec_r_q  <= NO_ROW;
			for (int i = 0; i < 3; i++) v_q[i] <= '0;
		end else if (cmd.var_load) begin
			if (nvalid_q == 2'd3 && peak > $signed({2'b00, threshold_q})) begin
				if (peak > best_v_q) begin
					sec_v_q  <= best_v_q;
					sec_r_q  <= best_r_q;
					best_v_q <= peak;
					best_r_q <= at;
				end else if (peak > sec_v_q) begin
					sec_v_q <= peak;
					sec_r_q <= at;
				end
			end
			v_q[0] <= v_q[1];
			v_q[1] <= v_q[2];
			v_q[2] <= var_new;
			if (nvalid_q != 2'd3) nvalid_q <= nvalid_q + 2'd1;
			row_q <= row_q + 13'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (best_r_q >= 0 && sec_r_q >= 0) begin
				first_boundary  <= (best_r_q < sec_r_q) ? best_r_q : sec_r_q;
				second_boundary <= (best_r_q < sec_r_q) ? sec_r_q : best_r_q;
				peaks_found     <= 2'd2;
			end else if (best_r_q >= 0) begin
				first_boundary  <= best_r_q;
				second_boundary <= NO_ROW;
				peaks_found     <= 2'd1;
			end else begin
				first_boundary  <= NO_ROW;
				second_boundary <= NO_ROW;
				peaks_found     <= 2'd0;
			end
		end
	end

	`RVB_ASSERT_IMPL(a_best_ge_second, clk, arst_n, 1'b1, best_v_q >= sec_v_q, "peak order broken")
	`RVB_ASSERT_NEXT(a_clear_rows, clk, arst_n, cmd.clear, row_q == '0, "row index not cleared")
	`RVB_ASSERT_IMPL(a_var_fits, clk, arst_n, cmd.var_load, quo[DivW-1:VarW] == '0, "variance overflow")
endmodule

### rtl/rvbf_ctrl.sv
`include "row_variance_boundary_finder_assert.svh"
module rvbf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                last_in_frame,
	output logic                out_valid,
	input  logic                out_stall,
	input  rvbf_pkg::rvbf_sts_t sts,
	output rvbf_pkg::rvbf_cmd_t cmd
);
	import rvbf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0, S_MEAN = 3'd1, S_PROD = 3'd2,
		S_DEV = 3'd3, S_VAR = 3'd4, S_EMIT = 3'd5, S_OUT = 3'd6, S_VSTART = 3'd7;

	logic [2:0] state_q, state_d;
	logic       last_q;
	logic       acc;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.accum = 1'b1;
					if (sts.row_end && sts.row_counts) begin
						cmd.close_row = 1'b1;
						state_d = S_MEAN;
					end else if (last_in_frame) begin
						state_d = S_EMIT;
					end
				end
			end
			S_MEAN: begin
				cmd.div_start = 1'b1;
				state_d = S_PROD;
			end
			S_PROD: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_d = S_DEV;
				end
			end
			S_DEV: begin
				cmd.dev_load = 1'b1;
				state_d = S_VSTART;
			end
			S_VSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_var = 1'b1;
				state_d = S_VAR;
			end
			S_VAR: begin
				cmd.div_sel_var = 1'b1;
				if (sts.div_done) begin
					cmd.var_load = 1'b1;
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.clear = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) last_q <= last_in_frame;
		end
	end

	`RVB_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, in_stall, "accept while busy")
	`RVB_ASSERT_NEXT(a_emit_out, clk, arst_n, cmd.emit, out_valid, "result lost")
	`RVB_ASSERT_IMPL(a_one_op, clk, arst_n, 1'b1, $onehot0({cmd.accum, cmd.var_load, cmd.emit}), "overlapping commands")
endmodule

### rtl/row_variance_boundary_finder.sv
// Row variance boundary finder.
// Input channel: in_valid/in_stall carry one pixel (three 8-bit channels and
// last_in_frame) per transfer in raster order. Output channel:
// out_valid/out_stall carry one result per frame: the two strongest
// third-difference peak rows, ascending, -1 where absent, and the count.
// A pixel that does not end a row only adds into the row sums. A row-ending
// pixel inside the analyzed height runs the shared restoring divider twice,
// once for the mean and once for the variance, with a product stage, a
// deviation stage and a divider start state between.
// The frame's last pixel passes through an emit state before out_valid rises.
// Configuration: cfg_we writes row_width (index 0) or peak_threshold
// (index 1) from cfg_wdata at the clock edge; write only while idle.
// Reset (arst_n low) clears the row sums, variance history and peak ranking,
// sets row_width 640 and threshold 30. While the receiver stalls, the result
// holds on the output ports and no new pixel is accepted.
module row_variance_boundary_finder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         first_channel,
	input  logic [7:0]         second_channel,
	input  logic [7:0]         third_channel,
	input  logic               last_in_frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [12:0] first_boundary,
	output logic signed [12:0] second_boundary,
	output logic [1:0]         peaks_found,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata
);
	import rvbf_pkg::*;

	rvbf_cmd_t   cmd;
	rvbf_sts_t   sts;
	logic [12:0] row_width_q;
	logic [15:0] threshold_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RESET_ROW_WIDTH;
			threshold_q <= RESET_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_wdata[12:0];
				REG_THRESHOLD: threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rvbf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.last_in_frame(last_in_frame), .out_valid(out_valid),
		.out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	rvbf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.first_channel(first_channel), .second_channel(second_channel),
		.third_channel(third_channel), .last_in_frame(last_in_frame),
		.row_width_q(row_width_q), .threshold_q(threshold_q),
		.first_boundary(first_boundary), .second_boundary(second_boundary),
		.peaks_found(peaks_found)
	);
endmodule

### dv/tb_row_variance_boundary_finder.sv
`timescale 1ns / 1ps

module tb_row_variance_boundary_finder;
	import rvbf_pkg::*;

	// Step kinds of the directed table
	typedef enum logic [1:0] {STEP_PIXEL, STEP_WRITE} step_kind_e;

	typedef struct {
		step_kind_e       kind;
		logic [7:0]       a, b, c;
		logic             last;
		logic             pinned;      // result typed in below, not predicted
		logic signed [12:0] lo, hi;
		logic [1:0]       found;
		logic             reg_idx;
		logic [15:0]      reg_val;
	} step_t;

	typedef struct {
		logic signed [12:0] lo, hi;
		logic [1:0]         found;
	} boundary_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         first_channel;
	logic [7:0]         second_channel;
	logic [7:0]         third_channel;
	logic               last_in_frame;
	logic               out_valid;
	logic               out_stall;
	logic signed [12:0] first_boundary;
	logic signed [12:0] second_boundary;
	logic [1:0]         peaks_found;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_wdata;

	// Pinned expectation travels alongside the pixel it belongs to
	logic               pin_valid;
	boundary_t          pin_result;

	boundary_t          boundaries_due[$];
	bit                 failed;
	bit                 calm;          // no idling on either side while set
	int                 pixels_sent;

	// Predictor state
	logic [12:0]        pr_width;
	logic [15:0]        pr_threshold;
	longint             pr_count, pr_row, pr_sum, pr_sq;
	longint             pr_var [3];
	int                 pr_var_seen;
	longint             pr_best_val, pr_second_val;
	int                 pr_best_row, pr_second_row;

	row_variance_boundary_finder dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20ns * 8_000_000);
		$display("row_variance_boundary_finder regression: fail");
		$finish;
	end

	function automatic void clear_frame_state();
		pr_count = 0;
		pr_row = 0;
		pr_sum = 0;
		pr_sq = 0;
		pr_var = '{0, 0, 0};
		pr_var_seen = 0;
		pr_best_val = -1000;
		pr_second_val = -1000;
		pr_best_row = -1;
		pr_second_row = -1;
	endfunction

	function automatic longint active_width();
		if (pr_width == 0) return 1;
		if (pr_width > MaxWidth) return MaxWidth;
		return pr_width;
	endfunction

	// Fold the finished row into the variance history and the peak ranking
	function automatic void finish_row();
		longint mean, dev, v, p;
		if (pr_count == 0 || pr_row >= MaxHeight) return;
		mean = pr_sum / pr_count;
		dev = pr_sq + pr_count * mean * mean - 2 * mean * pr_sum;
		v = dev / pr_count;
		if (pr_var_seen >= 3) begin
			p = pr_var[0] - 3 * pr_var[1] + 3 * pr_var[2] - v;
			if (p < 0) p = -p;
			if (p > pr_threshold) begin
				if (p > pr_best_val) begin
					pr_second_val = pr_best_val;
					pr_second_row = pr_best_row;
					pr_best_val = p;
					pr_best_row = int'(pr_row) - 3;
				end else if (p > pr_second_val) begin
					pr_second_val = p;
					pr_second_row = int'(pr_row) - 3;
				end
			end
		end
		pr_var[0] = pr_var[1];
		pr_var[1] = pr_var[2];
		pr_var[2] = v;
		if (pr_var_seen < 3) pr_var_seen++;
		pr_row++;
	endfunction

	// Advance the predictor by one pixel; returns 1 when a frame result falls out
	function automatic bit predict_pixel(input logic [7:0] a, b, c, input logic l,
			output boundary_t res);
		longint y;
		y = (longint'(a) + b + c) / 3;
		pr_sum += y;
		pr_sq += y * y;
		pr_count++;
		if (pr_count >= active_width() || l) begin
			finish_row();
			pr_count = 0;
			pr_sum = 0;
			pr_sq = 0;
		end
		if (!l) return 0;
		if (pr_best_row >= 0 && pr_second_row >= 0) begin
			res.lo = 13'(pr_best_row < pr_second_row ? pr_best_row : pr_second_row);
			res.hi = 13'(pr_best_row < pr_second_row ? pr_second_row : pr_best_row);
			res.found = 2'd2;
		end else if (pr_best_row >= 0) begin
			res.lo = 13'(pr_best_row);
			res.hi = NO_ROW;
			res.found = 2'd1;
		end else begin
			res.lo = NO_ROW;
			res.hi = NO_ROW;
			res.found = 2'd0;
		end
		clear_frame_state();
		return 1;
	endfunction

	// Watch both channels and the register port at every edge
	always @(posedge clk) begin
		boundary_t due;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_ROW_WIDTH) pr_width = cfg_wdata[12:0];
				else pr_threshold = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				if (predict_pixel(first_channel, second_channel, third_channel,
						last_in_frame, due))
					boundaries_due.push_back(pin_valid ? pin_result : due);
			end
			if (out_valid && !out_stall) begin
				if (boundaries_due.size() == 0) begin
					$error("result transfer with no frame outstanding");
					failed = 1;
				end else begin
					due = boundaries_due.pop_front();
					if (first_boundary !== due.lo) begin
						$error("first_boundary: expected %0d, got %0d", due.lo, first_boundary);
						failed = 1;
					end
					if (second_boundary !== due.hi) begin
						$error("second_boundary: expected %0d, got %0d", due.hi,
							second_boundary);
						failed = 1;
					end
					if (peaks_found !== due.found) begin
						$error("peaks_found: expected %0d, got %0d", due.found, peaks_found);
						failed = 1;
					end
				end
			end
		end
	end

	// Receiver: hold off a random number of cycles, then take one result
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_pixel(input logic [7:0] a, b, c, input logic l,
			input logic pin, input boundary_t pres);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_channel <= a;
		second_channel <= b;
		third_channel <= c;
		last_in_frame <= l;
		pin_valid <= pin;
		pin_result <= pres;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	// Drop valid, wait for every frame result, then let the divider settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (boundaries_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] level_near(input int base);
		int v;
		v = base + $urandom_range(0, 20) - 10;
		return 8'(v < 0 ? 0 : (v > 255 ? 255 : v));
	endfunction

	// One frame: rows of a chosen brightness profile, a few rows busy enough to peak
	task automatic send_frame(input int width, input int rows, input bit cut_short);
		int base, spread, n;
		logic [7:0] a, b, c;
		boundary_t none;
		none = '{NO_ROW, NO_ROW, 2'd0};
		for (int r = 0; r < rows; r++) begin
			base = $urandom_range(0, 255);
			spread = ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(0, 10);
			n = (cut_short && r == rows - 1) ? $urandom_range(1, width) : width;
			for (int p = 0; p < n; p++) begin
				if ($urandom_range(0, 9) == 0) begin
					a = 8'($urandom); b = 8'($urandom); c = 8'($urandom);
				end else begin
					a = level_near(base + ((p % 2) ? spread : -spread));
					b = level_near(base);
					c = level_near(base + ((p % 2) ? spread : -spread));
				end
				send_pixel(a, b, c, (r == rows - 1 && p == n - 1), 1'b0, none);
			end
		end
	endtask

	step_t plan [$];

	initial begin
		int width;
		step_t s;

		arst_n = 1'b0;
		in_valid = 1'b0;
		first_channel = '0;
		second_channel = '0;
		third_channel = '0;
		last_in_frame = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROW_WIDTH;
		cfg_wdata = '0;
		pin_valid = 1'b0;
		pin_result = '{NO_ROW, NO_ROW, 2'd0};
		failed = 0;
		calm = 0;
		pixels_sent = 0;
		pr_width = RESET_ROW_WIDTH;
		pr_threshold = RESET_THRESHOLD;
		clear_frame_state();

		// Directed: single-pixel frames at reset settings, one obvious peak,
		// width clamps, a width change inside a row and short final rows
		s = '{STEP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);
		s.a = 8'd255; s.b = 8'd255; s.c = 8'd255;
		plan.push_back(s);
		s = '{STEP_WRITE, 0, 0, 0, 0, 0, NO_ROW, NO_ROW, 2'd0, REG_ROW_WIDTH, 16'd2};
		plan.push_back(s);
		s.reg_idx = REG_THRESHOLD; s.reg_val = 16'd0;
		plan.push_back(s);
		// Row 0 swings 0..255, rows 1..3 flat: one peak of 16256 at row 0
		s = '{STEP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);
		s.a = 8'd255; s.b = 8'd255; s.c = 8'd255;
		plan.push_back(s);
		s.a = 8'd0; s.b = 8'd0; s.c = 8'd0;
		repeat (5) plan.push_back(s);
		s.last = 1'b1; s.pinned = 1'b1; s.lo = 13'sd0; s.found = 2'd1;
		plan.push_back(s);
		s = '{STEP_WRITE, 0, 0, 0, 0, 0, NO_ROW, NO_ROW, 2'd0, REG_ROW_WIDTH, 16'h1FFF};
		plan.push_back(s);
		s = '{STEP_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, 1'b0, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);
		plan.push_back(s);
		s = '{STEP_WRITE, 0, 0, 0, 0, 0, NO_ROW, NO_ROW, 2'd0, REG_ROW_WIDTH, 16'd0};
		plan.push_back(s);
		s = '{STEP_PIXEL, 8'd7, 8'd200, 8'd9, 1'b0, 1'b0, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);
		s.a = 8'd200; s.b = 8'd100; s.c = 8'd50; s.last = 1'b1;
		plan.push_back(s);
		s = '{STEP_WRITE, 0, 0, 0, 0, 0, NO_ROW, NO_ROW, 2'd0, REG_ROW_WIDTH, 16'd3};
		plan.push_back(s);
		s = '{STEP_PIXEL, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);
		s.a = 8'd0; s.last = 1'b1;
		plan.push_back(s);
		s = '{STEP_WRITE, 0, 0, 0, 0, 0, NO_ROW, NO_ROW, 2'd0, REG_THRESHOLD, 16'hFFFF};
		plan.push_back(s);
		s = '{STEP_PIXEL, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, NO_ROW, NO_ROW, 2'd0, 1'b0, 16'd0};
		plan.push_back(s);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_pixel(plan[i].a, plan[i].b, plan[i].c, plan[i].last, plan[i].pinned,
					'{plan[i].lo, plan[i].hi, plan[i].found});
			end
		end
		drain();

		// Random phases: new settings, a handful of frames, sometimes a row left open
		while (pixels_sent < 560) begin
			calm = ($urandom_range(0, 4) == 0);
			width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
			write_reg(REG_ROW_WIDTH, 16'(width));
			case ($urandom_range(0, 5))
				0: write_reg(REG_THRESHOLD, 16'd0);
				1: write_reg(REG_THRESHOLD, 16'hFFFF);
				2: write_reg(REG_THRESHOLD, 16'($urandom));
				default: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 3000)));
			endcase
			if (width == 0) width = 1;
			repeat ($urandom_range(1, 4))
				send_frame(width, $urandom_range(1, 12), $urandom_range(0, 3) == 0);
			// Leave a partial row open so the next width lands mid-row
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, width))
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0,
						'{NO_ROW, NO_ROW, 2'd0});
			drain();
		end

		// Close any open row
		send_frame(2, 1, 1'b0);
		drain();

		if (!failed)
			$display("row_variance_boundary_finder regression: pass");
		else
			$display("row_variance_boundary_finder regression: fail");
		$finish;
	end
endmodule

### row_variance_boundary_finder.f
+incdir+rtl
rtl/rvbf_pkg.sv
rtl/rvbf_divider.sv
rtl/rvbf_datapath.sv
rtl/rvbf_ctrl.sv
rtl/row_variance_boundary_finder.sv
dv/tb_row_variance_boundary_finder.sv
